>>> sv/brav_pkg.sv
package brav_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int AVG_W = 32;
	localparam int TW_W = 48;
	localparam int SUM_W = 64;
	localparam int FACT_W = 16;
	localparam int FACT_FRAC = 8;
	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int QUOT_W = AVG_W + 1;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_INIT_AVG = 2'd0;
	localparam logic [IDX_W-1:0] REG_REGR_WEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_PERSISTENCE = 2'd2;

	// shift applied to the product before it enters the accumulator
	typedef enum logic [1:0] {
		SH_NONE = 2'd0,
		SH_REG = 2'd1,
		SH_WORD = 2'd2
	} sh_t;

	typedef struct packed {
		logic load;
		logic add;
		logic neg;
		sh_t sh;
	} mac_cmd_t;

endpackage

>>> sv/brav_mac.sv
module brav_mac import brav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_W = 90
) (
	input logic clk,
	input logic [MUL_W-1:0] a,
	input logic [MUL_W-1:0] b,
	input mac_cmd_t cmd,
	input logic [ACC_W-1:0] load_val,
	output logic [PROD_W-1:0] prod,
	output logic [ACC_W-1:0] acc
);

	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] term_ext;
	logic [ACC_W-1:0] term;

	assign term_ext = ACC_W'(prod_q);

	always_comb begin
		unique case (cmd.sh)
			SH_NONE: term = term_ext;
			SH_REG: term = term_ext << (FRAC_BITS - FACT_FRAC);
			SH_WORD: term = term_ext << MUL_W;
			default: term = term_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= a * b;
		if (cmd.load) begin
			acc_q <= load_val;
		end else if (cmd.add) begin
			acc_q <= cmd.neg ? (acc_q - term) : (acc_q + term);
		end
	end

	assign prod = prod_q;
	assign acc = acc_q;

endmodule

>>> sv/brav_div.sv
module brav_div import brav_pkg::*; #(
	parameter int NUM_W = 90,
	parameter int DEN_W = 58
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_W-1:0] dividend,
	input logic [DEN_W-1:0] divisor,
	output logic busy,
	output logic [QUOT_W-1:0] quot,
	output logic ovf
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic ovf_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic fits;

	// restoring division, one quotient bit per cycle, msb first
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quot_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			// only the low bits are kept, a bit lost off the top marks overflow
			ovf_q <= ovf_q | quot_q[QUOT_W-1];
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign ovf = ovf_q;

endmodule

>>> sv/batched_regressing_average.sv
// sample beat: taken while idle, another item may follow on the next clock
// update beat: multiply-accumulate steps, then the divider; ACC_W = max(64 + FRAC_BITS, 88) + 2, 90 at defaults
// the update runs the restoring divider, one quotient bit per cycle; zero weight skips it
// one item in work at a time; a finished result waits in the output register while items flow in
// arst_n asynchronously clears registers, batch, aggregate weight and average to zero
module batched_regressing_average import brav_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic action,
	input logic signed [AVG_W-1:0] sample,
	output logic result_valid,
	input logic result_stall,
	output logic signed [AVG_W-1:0] average,
	output logic [TW_W-1:0] avg_weight,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_index,
	input logic [AVG_W-1:0] wr_data
);

	localparam int PW_W = FACT_W + TW_W;
	localparam int PREV_W = PW_W - FACT_FRAC;
	localparam int BW_W = COUNT_BITS + FRAC_BITS;
	localparam int W_W = ((BW_W > PREV_W) ? BW_W : PREV_W) + 2;
	localparam int SL_W = SUM_W + FRAC_BITS;
	localparam int PT_W = PREV_W + AVG_W;
	localparam int ACC_W = ((SL_W > PT_W) ? SL_W : PT_W) + 2;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TW_W-1:0] TW_MAX = '1;
	localparam logic [QUOT_W-1:0] NEG_LIM = QUOT_W'(1) << (AVG_W - 1);
	localparam logic [QUOT_W-1:0] POS_LIM = NEG_LIM - 1'b1;
	localparam logic [SUM_W-1:0] SUM_MIN = SUM_W'(1) << (SUM_W - 1);
	localparam logic [SUM_W-1:0] SUM_MAX = ~SUM_MIN;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_PW_LO = 10'b0000000010,
		ST_PW_HI = 10'b0000000100,
		ST_RW = 10'b0000001000,
		ST_PV_LO = 10'b0000010000,
		ST_PV_HI = 10'b0000100000,
		ST_ACC_LAST = 10'b0001000000,
		ST_PREP = 10'b0010000000,
		ST_DIV = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	logic [AVG_W-1:0] start_avg_q;
	logic [FACT_W-1:0] regr_w_q;
	logic [FACT_W-1:0] pers_q;
	logic [SUM_W-1:0] batch_sum_q;
	logic [COUNT_BITS-1:0] batch_count_q;
	logic [TW_W-1:0] agg_w_q;
	logic [AVG_W-1:0] agg_avg_q;
	logic [PW_W-1:0] pw_q;
	logic [W_W-1:0] w_q;
	logic result_valid_q;
	logic [AVG_W-1:0] average_q;
	logic [TW_W-1:0] avg_weight_q;

	logic item_fire;
	logic done_fire;
	logic [SUM_W:0] sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic [AVG_W-1:0] init_mag;
	logic [AVG_W-1:0] prev_mag;
	logic [PREV_W-1:0] prev_w;

	mac_cmd_t mac_cmd;
	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;
	logic [ACC_W-1:0] acc_load_val;
	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0] acc;

	logic acc_neg;
	logic [ACC_W-1:0] half_w;
	logic [ACC_W-1:0] dividend;
	logic div_start;
	logic div_busy;
	logic [QUOT_W-1:0] quot;
	logic quot_ovf;
	logic w_zero;
	logic avg_sat;
	logic [AVG_W-1:0] mag_sel;
	logic [AVG_W-1:0] avg_next;
	logic [TW_W-1:0] weight_sat;

	assign item_stall = (state_q != ST_IDLE);
	assign item_fire = item_valid && (state_q == ST_IDLE);
	assign done_fire = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	// saturating batch accumulation
	assign sum_ext = {batch_sum_q[SUM_W-1], batch_sum_q}
		+ {{(SUM_W + 1 - AVG_W){sample[AVG_W-1]}}, sample};
	assign sum_sat = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
		? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];

	assign init_mag = start_avg_q[AVG_W-1] ? (~start_avg_q + 1'b1) : start_avg_q;
	assign prev_mag = agg_avg_q[AVG_W-1] ? (~agg_avg_q + 1'b1) : agg_avg_q;
	assign prev_w = pw_q[PW_W-1:FACT_FRAC];

	assign acc_load_val = {{(ACC_W - SUM_W){batch_sum_q[SUM_W-1]}}, batch_sum_q} << FRAC_BITS;

	always_comb begin
		mac_cmd = '{load: 1'b0, add: 1'b0, neg: 1'b0, sh: SH_NONE};
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PW_LO: begin
				mac_cmd.load = 1'b1;
				mul_a = MUL_W'(pers_q);
				mul_b = agg_w_q[MUL_W-1:0];
			end
			ST_PW_HI: begin
				mul_a = MUL_W'(pers_q);
				mul_b = MUL_W'(agg_w_q[TW_W-1:MUL_W]);
			end
			ST_RW: begin
				mul_a = MUL_W'(regr_w_q);
				mul_b = init_mag;
			end
			ST_PV_LO: begin
				mac_cmd.add = 1'b1;
				mac_cmd.neg = start_avg_q[AVG_W-1];
				mac_cmd.sh = SH_REG;
				mul_a = prev_w[MUL_W-1:0];
				mul_b = prev_mag;
			end
			ST_PV_HI: begin
				mac_cmd.add = 1'b1;
				mac_cmd.neg = agg_avg_q[AVG_W-1];
				mul_a = MUL_W'(prev_w[PREV_W-1:MUL_W]);
				mul_b = prev_mag;
			end
			ST_ACC_LAST: begin
				mac_cmd.add = 1'b1;
				mac_cmd.neg = agg_avg_q[AVG_W-1];
				mac_cmd.sh = SH_WORD;
			end
			default: begin
			end
		endcase
	end

	brav_mac #(
		.FRAC_BITS(FRAC_BITS),
		.ACC_W(ACC_W)
	) u_mac (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.cmd(mac_cmd),
		.load_val(acc_load_val),
		.prod(prod),
		.acc(acc)
	);

	// magnitude plus half the weight gives round half away from zero
	assign acc_neg = acc[ACC_W-1];
	assign half_w = ACC_W'(w_q >> 1);
	assign dividend = acc_neg ? (half_w - acc) : (acc + half_w);
	assign w_zero = (w_q == '0);
	assign div_start = (state_q == ST_PREP) && !w_zero;

	brav_div #(
		.NUM_W(ACC_W),
		.DEN_W(W_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dividend),
		.divisor(w_q),
		.busy(div_busy),
		.quot(quot),
		.ovf(quot_ovf)
	);

	always_comb begin
		avg_sat = quot_ovf || (quot > (acc_neg ? NEG_LIM : POS_LIM));
		mag_sel = avg_sat ? (acc_neg ? NEG_LIM[AVG_W-1:0] : POS_LIM[AVG_W-1:0]) : quot[AVG_W-1:0];
		if (w_zero) begin
			avg_next = start_avg_q;
		end else if (acc_neg) begin
			avg_next = ~mag_sel + 1'b1;
		end else begin
			avg_next = mag_sel;
		end
	end

	assign weight_sat = (|w_q[W_W-1:TW_W]) ? TW_MAX : w_q[TW_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire && action) begin
					state_d = ST_PW_LO;
				end
			end
			ST_PW_LO: state_d = ST_PW_HI;
			ST_PW_HI: state_d = ST_RW;
			ST_RW: state_d = ST_PV_LO;
			ST_PV_LO: state_d = ST_PV_HI;
			ST_PV_HI: state_d = ST_ACC_LAST;
			ST_ACC_LAST: state_d = ST_PREP;
			ST_PREP: state_d = w_zero ? ST_DONE : ST_DIV;
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (done_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_avg_q <= '0;
			regr_w_q <= '0;
			pers_q <= '0;
			batch_sum_q <= '0;
			batch_count_q <= '0;
			agg_w_q <= '0;
			agg_avg_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_index)
					REG_INIT_AVG: start_avg_q <= wr_data;
					REG_REGR_WEIGHT: regr_w_q <= wr_data[FACT_W-1:0];
					REG_PERSISTENCE: pers_q <= wr_data[FACT_W-1:0];
					default: begin
					end
				endcase
			end
			if (item_fire && !action) begin
				batch_sum_q <= sum_sat;
				if (batch_count_q != COUNT_MAX) begin
					batch_count_q <= batch_count_q + 1'b1;
				end
			end
			if (done_fire) begin
				batch_sum_q <= '0;
				batch_count_q <= '0;
				agg_w_q <= weight_sat;
				agg_avg_q <= avg_next;
			end
			if (done_fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PW_HI) begin
			pw_q <= PW_W'(prod);
		end else if (state_q == ST_RW) begin
			pw_q <= pw_q + (PW_W'(prod) << MUL_W);
		end
		if (state_q == ST_PV_LO) begin
			w_q <= (W_W'(batch_count_q) << FRAC_BITS)
				+ (W_W'(regr_w_q) << (FRAC_BITS - FACT_FRAC))
				+ W_W'(prev_w);
		end
		if (done_fire) begin
			average_q <= avg_next;
			avg_weight_q <= weight_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign average = average_q;
	assign avg_weight = avg_weight_q;

`ifndef SYNTHESIS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the done step");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider busy outside the divide step");

	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> (batch_count_q == '0 && batch_sum_q == '0))
		else $error("batch not cleared after update");
`endif

endmodule
